>>> rtl/tkf_pkg.sv
// Shared types and default constants for the streaming top-k frequency block.
package tkf_pkg;

	localparam int TKF_K_MAX      = 8;
	localparam int TKF_VALUE_BITS = 10;
	localparam int TKF_COUNT_BITS = 16;
	localparam int TKF_KCFG_BITS  = 4;
	localparam int TKF_RANK_BITS  = 3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_BUBBLE,
		ST_FINAL,
		ST_EMIT
	} tkf_state_t;

	// Operations on the rank list: a count update with spare slot fill, or one slot write.
	typedef struct packed {
		logic upd;
		logic wr;
	} tkf_rl_op_t;

endpackage

>>> rtl/tkf_count_mem.sv
// Frequency count memory: one write port and one registered read port.
module tkf_count_mem import tkf_pkg::*; #(
	parameter int VALUE_BITS = TKF_VALUE_BITS,
	parameter int COUNT_BITS = TKF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [VALUE_BITS-1:0] waddr,
	input  logic [COUNT_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [VALUE_BITS-1:0] raddr,
	output logic [COUNT_BITS-1:0] rdata
);

	logic [COUNT_BITS-1:0] mem [2**VALUE_BITS];
	logic [COUNT_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tkf_rank_list.sv
// Ranked slot list with a cached count per slot, the rank search and the tail scan.
module tkf_rank_list import tkf_pkg::*; #(
	parameter int K_MAX      = TKF_K_MAX,
	parameter int VALUE_BITS = TKF_VALUE_BITS,
	parameter int COUNT_BITS = TKF_COUNT_BITS,
	localparam int IW        = $clog2(K_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tkf_rl_op_t            op,
	input  logic [VALUE_BITS-1:0] x,
	input  logic [COUNT_BITS-1:0] new_cnt,
	input  logic [IW-1:0]         keff,
	input  logic [IW-1:0]         wr_idx,
	input  logic [VALUE_BITS-1:0] wr_val,
	input  logic [COUNT_BITS-1:0] wr_cnt,
	input  logic [IW-1:0]         rd_idx,
	output logic [VALUE_BITS-1:0] rd_val,
	output logic [COUNT_BITS-1:0] rd_cnt,
	output logic [IW-1:0]         found_idx,
	output logic                  more_after
);

	logic [VALUE_BITS-1:0] val_q [K_MAX+1];
	logic [COUNT_BITS-1:0] cnt_q [K_MAX+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= K_MAX; i++) begin
				val_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i <= K_MAX; i++) begin
				if (op.upd) begin
					// The spare slot takes the new value; every copy of it gets the new count.
					if (IW'(i) == keff) begin
						val_q[i] <= x;
						cnt_q[i] <= new_cnt;
					end else if (val_q[i] == x) begin
						cnt_q[i] <= new_cnt;
					end
				end else if (op.wr && (IW'(i) == wr_idx)) begin
					val_q[i] <= wr_val;
					cnt_q[i] <= wr_cnt;
				end
			end
		end
	end

	assign rd_val = val_q[rd_idx];
	assign rd_cnt = cnt_q[rd_idx];

	// First tracked slot that holds x, or the last tracked rank when x is absent.
	always_comb begin
		found_idx = keff - IW'(1);
		for (int i = K_MAX - 1; i >= 0; i--) begin
			if ((i < int'(keff)) && (val_q[i] == x)) begin
				found_idx = IW'(i);
			end
		end
	end

	always_comb begin
		more_after = 1'b0;
		for (int i = 0; i < K_MAX; i++) begin
			if ((val_q[i] != '0) && (i < int'(keff)) && (i > int'(rd_idx))) begin
				more_after = 1'b1;
			end
		end
	end

endmodule

>>> rtl/top_k_frequent_stream_top.sv
// Streaming top-k frequency ranker: top level with the sequencer and the output register.
//
// Input channel: in_valid / in_stall with one value per word. Output channel:
// out_valid / out_stall with ranked_value, rank and last; each input word yields the
// nonzero entries of the first k tracked ranks, most frequent first, last set on the
// final one. An input word of zero changes nothing but still reports the ranking.
// cfg_write / cfg_data set the number of tracked ranks; write it only while idle.
// After reset the count memory is cleared one entry per cycle over all 2**VALUE_BITS
// entries, with in_stall held high. Each word then passes through the idle state that
// accepts it, the count update, a load of the bubble pass, the bubble steps from the
// word's slot up to the head, a write-back at the head and a walk over the k tracked
// slots; a zero word goes from the idle state straight to the walk. The bubble pass
// reads one slot per cycle. When the receiver stalls, the output register holds its
// word and the slot walk waits; the next input word is taken once the walk has ended,
// even while the final result is waiting.
module top_k_frequent_stream_top import tkf_pkg::*; #(
	parameter int K_MAX      = TKF_K_MAX,
	parameter int VALUE_BITS = TKF_VALUE_BITS,
	parameter int COUNT_BITS = TKF_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [TKF_KCFG_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [VALUE_BITS-1:0]    value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [VALUE_BITS-1:0]    ranked_value,
	output logic [TKF_RANK_BITS-1:0] rank,
	output logic                     last
);

	localparam int IW = $clog2(K_MAX + 1);

	tkf_state_t state_q, state_d;

	logic [TKF_KCFG_BITS-1:0] k_cfg_q;
	logic [IW-1:0]            keff;
	logic [VALUE_BITS-1:0]    clr_q;
	logic [VALUE_BITS-1:0]    x_q;
	logic [IW-1:0]            keff_q;
	logic [IW-1:0]            ptr_q;
	logic [IW-1:0]            n_q;
	logic [VALUE_BITS-1:0]    cur_val_q;
	logic [COUNT_BITS-1:0]    cur_cnt_q;

	logic                     out_valid_q;
	logic [VALUE_BITS-1:0]    out_val_q;
	logic [TKF_RANK_BITS-1:0] out_rank_q;
	logic                     out_last_q;

	logic                  mem_we;
	logic [VALUE_BITS-1:0] mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [COUNT_BITS-1:0] mem_rdata;
	logic [COUNT_BITS-1:0] new_cnt;

	tkf_rl_op_t            rl_op;
	logic [IW-1:0]         wr_idx;
	logic [VALUE_BITS-1:0] wr_val;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic [VALUE_BITS-1:0] rd_val;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [IW-1:0]         found_idx;
	logic                  more_after;

	logic accept;
	logic swap;
	logic out_free;
	logic emit_step;
	logic emit_load;
	logic walk_done;

	always_comb begin
		if (k_cfg_q == '0) begin
			keff = IW'(1);
		end else if (int'(k_cfg_q) > K_MAX) begin
			keff = IW'(K_MAX);
		end else begin
			keff = IW'(k_cfg_q);
		end
	end

	assign new_cnt = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
	assign swap    = (rd_cnt < cur_cnt_q) || ((rd_cnt == cur_cnt_q) && (rd_val > cur_val_q));
	assign out_free  = !out_valid_q || !out_stall;
	assign walk_done = (ptr_q == keff_q - IW'(1));

	tkf_count_mem #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_count_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(value),
		.rdata(mem_rdata)
	);

	tkf_rank_list #(
		.K_MAX     (K_MAX),
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_rank_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (rl_op),
		.x         (x_q),
		.new_cnt   (new_cnt),
		.keff      (keff_q),
		.wr_idx    (wr_idx),
		.wr_val    (wr_val),
		.wr_cnt    (wr_cnt),
		.rd_idx    (ptr_q),
		.rd_val    (rd_val),
		.rd_cnt    (rd_cnt),
		.found_idx (found_idx),
		.more_after(more_after)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		accept    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = x_q;
		mem_wdata = new_cnt;
		mem_re    = 1'b0;
		rl_op     = '0;
		wr_idx    = ptr_q + IW'(1);
		wr_val    = swap ? rd_val : cur_val_q;
		wr_cnt    = swap ? rd_cnt : cur_cnt_q;
		emit_step = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_re   = in_valid;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = (value != '0) ? ST_UPDATE : ST_EMIT;
				end
			end
			ST_UPDATE: begin
				mem_we    = 1'b1;
				rl_op.upd = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_BUBBLE;
			end
			ST_BUBBLE: begin
				rl_op.wr = 1'b1;
				if (ptr_q == '0) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				// The word carried through the pass settles at the head.
				rl_op.wr = 1'b1;
				wr_idx   = '0;
				wr_val   = cur_val_q;
				wr_cnt   = cur_cnt_q;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				emit_step = (rd_val == '0) || out_free;
				emit_load = (rd_val != '0) && out_free;
				if (emit_step && walk_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_cfg_q <= TKF_KCFG_BITS'(2);
			clr_q   <= '0;
		end else begin
			if (cfg_write) begin
				k_cfg_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + VALUE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q    <= value;
					keff_q <= keff;
					ptr_q  <= '0;
					n_q    <= '0;
				end
			end
			ST_UPDATE: begin
				ptr_q <= found_idx + IW'(1);
			end
			ST_LOAD: begin
				cur_val_q <= rd_val;
				cur_cnt_q <= rd_cnt;
				ptr_q     <= ptr_q - IW'(1);
			end
			ST_BUBBLE: begin
				if (!swap) begin
					cur_val_q <= rd_val;
					cur_cnt_q <= rd_cnt;
				end
				if (ptr_q != '0) begin
					ptr_q <= ptr_q - IW'(1);
				end
			end
			ST_FINAL: begin
				ptr_q <= '0;
				n_q   <= '0;
			end
			ST_EMIT: begin
				if (emit_step && !walk_done) begin
					ptr_q <= ptr_q + IW'(1);
				end
				if (emit_load) begin
					n_q <= n_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_val_q  <= rd_val;
			out_rank_q <= TKF_RANK_BITS'(n_q);
			out_last_q <= !more_after;
		end
	end

	assign out_valid    = out_valid_q;
	assign ranked_value = out_val_q;
	assign rank         = out_rank_q;
	assign last         = out_last_q;

endmodule

>>> rtl/tkf_checker.sv
// Port-level checks for the top-k frequency block, bound to the top level.
module tkf_checker import tkf_pkg::*; #(
	parameter int VALUE_BITS = TKF_VALUE_BITS
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [VALUE_BITS-1:0]    ranked_value,
	input logic [TKF_RANK_BITS-1:0] rank,
	input logic                     last
);

	logic [TKF_RANK_BITS-1:0] exp_rank_q;

	// Ranks count up from zero within one report and restart after the last word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rank_q <= '0;
		end else if (out_valid && !out_stall) begin
			exp_rank_q <= last ? '0 : rank + TKF_RANK_BITS'(1);
		end
	end

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rank == exp_rank_q))
		else $error("rank out of sequence");

	a_nonzero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ranked_value != '0))
		else $error("empty slot reported");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input word taken while the previous one is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ranked_value) && $stable(last)))
		else $error("stalled output word changed");

endmodule

bind top_k_frequent_stream_top tkf_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_tkf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.ranked_value(ranked_value),
	.rank        (rank),
	.last        (last)
);

>>> tb/tkf_ranking_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k frequency ranker: mirrors the count table and rank list and checks every result word.
module tkf_ranking_checker import tkf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [TKF_KCFG_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [TKF_VALUE_BITS-1:0] value,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [TKF_VALUE_BITS-1:0] ranked_value,
	input  logic [TKF_RANK_BITS-1:0]  rank,
	input  logic                      last,
	output int                        fail_count,
	output int                        pending,
	output int                        words_taken,
	output int                        results_checked
);

	localparam int VB = TKF_VALUE_BITS;
	localparam int CB = TKF_COUNT_BITS;
	localparam int KCFG_AT_RESET = 2;

	typedef struct packed {
		logic [VB-1:0]            ranked_value;
		logic [TKF_RANK_BITS-1:0] rank;
		logic                     last;
	} ranked_word_t;

	logic [CB-1:0]            hit_count [1 << VB];
	logic [VB-1:0]            ladder [TKF_K_MAX + 1];
	logic [TKF_KCFG_BITS-1:0] k_reg;
	ranked_word_t             ranking_due [$];

	initial begin
		for (int i = 0; i < (1 << VB); i++)
			hit_count[i] = '0;
		for (int i = 0; i <= TKF_K_MAX; i++)
			ladder[i] = '0;
		k_reg = TKF_KCFG_BITS'(KCFG_AT_RESET);
		fail_count = 0;
		pending = 0;
		words_taken = 0;
		results_checked = 0;
	end

	// Counts a nonzero word, moves it up the ladder by one bubble pass and queues the ranking.
	function automatic void tally_and_rank(input logic [VB-1:0] v);
		int k, spot, total, n;
		logic [VB-1:0] a, b;
		logic [CB-1:0] ca, cb;
		ranked_word_t w;
		k = (k_reg == 0) ? 1 : ((k_reg > TKF_K_MAX) ? TKF_K_MAX : int'(k_reg));
		if (v != 0) begin
			if (hit_count[v] != '1)
				hit_count[v] = hit_count[v] + 1'b1;
			ladder[k] = v;
			spot = k - 1;
			// Scanning downward leaves the first match in spot.
			for (int j = k - 1; j >= 0; j--)
				if (ladder[j] == v)
					spot = j;
			for (int j = spot; j >= 0; j--) begin
				a = ladder[j];
				b = ladder[j + 1];
				ca = (a == 0) ? '0 : hit_count[a];
				cb = (b == 0) ? '0 : hit_count[b];
				if (ca < cb || (ca == cb && a > b)) begin
					ladder[j] = b;
					ladder[j + 1] = a;
				end
			end
		end
		total = 0;
		for (int j = 0; j < k; j++)
			if (ladder[j] != 0)
				total++;
		n = 0;
		for (int j = 0; j < k; j++) begin
			if (ladder[j] != 0) begin
				w.ranked_value = ladder[j];
				w.rank = n[TKF_RANK_BITS-1:0];
				w.last = (n == total - 1);
				ranking_due = {ranking_due, w};
				n++;
			end
		end
	endfunction

	always @(posedge clk) begin : watch
		ranked_word_t want;
		if (arst_n) begin
			if (cfg_write)
				k_reg = cfg_data;
			if (in_valid && !in_stall) begin
				words_taken++;
				tally_and_rank(value);
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (ranking_due.size() == 0) begin
					$error("result word %0d at rank %0d arrived with nothing expected",
						ranked_value, rank);
					fail_count++;
				end else begin
					want = ranking_due.pop_front();
					if (ranked_value !== want.ranked_value) begin
						$error("ranked_value mismatch: expected %0d, got %0d",
							want.ranked_value, ranked_value);
						fail_count++;
					end
					if (rank !== want.rank) begin
						$error("rank mismatch: expected %0d, got %0d", want.rank, rank);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
		end
		pending <= ranking_due.size();
	end

endmodule

>>> tb/tb_top_k_frequent_stream_top.sv
`timescale 1ns / 1ps
// Testbench top for the top-k frequency ranker: clock, reset, word stimulus and verdict.
module tb_top_k_frequent_stream_top;
	import tkf_pkg::*;

	localparam int VB = TKF_VALUE_BITS;
	localparam int POOL = 10;
	localparam int SETTLE = 40;
	localparam int PHASE_WORDS = 33;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [TKF_KCFG_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [VB-1:0]            value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [VB-1:0]            ranked_value;
	logic [TKF_RANK_BITS-1:0] rank;
	logic                     last;

	int fail_count, pending, words_taken, results_checked;
	int k_writes = 0;
	bit calm = 1'b0;
	bit stall_en = 1'b1;
	logic [VB-1:0] pool [POOL];

	top_k_frequent_stream_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ranked_value(ranked_value),
		.rank        (rank),
		.last        (last)
	);

	tkf_ranking_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ranked_value   (ranked_value),
		.rank           (rank),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.words_taken    (words_taken),
		.results_checked(results_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Most words come from a small pool so that counts climb and ties happen.
	function automatic logic [VB-1:0] next_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return pool[$urandom_range(0, POOL - 1)];
		else if (r < 88)
			return VB'($urandom_range(1, (1 << VB) - 1));
		else if (r < 94)
			return '0;
		return $urandom_range(0, 1) ? {VB{1'b1}} : VB'(1);
	endfunction

	task automatic send_word(input logic [VB-1:0] v);
		int gap;
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender back until every queued ranking has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_k(input logic [TKF_KCFG_BITS-1:0] k);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		cfg_write <= 1'b0;
		k_writes++;
	endtask

	initial begin : rx_side
		int open_len, shut_len;
		forever begin
			open_len = stall_en ? $urandom_range(1, 12) : 1;
			shut_len = stall_en ? gap_len() : 0;
			repeat (open_len) @(posedge clk);
			if (shut_len > 0) begin
				out_stall <= 1'b1;
				repeat (shut_len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int k_plan [9];
		int guard;
		k_plan = '{3, 8, 1, 0, 5, 15, 2, 7, 4};
		k_plan[8] = $urandom_range(9, 14);
		for (int i = 0; i < POOL; i++)
			pool[i] = VB'($urandom_range(1, (1 << VB) - 1));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a zero word on the empty list, extremes, ties, and k out of range.
		send_word(0);
		send_word(1023);
		send_word(1);
		send_word(1);
		send_word(512);
		send_word(0);
		set_k(8);
		for (int v = 5; v <= 11; v++)
			send_word(VB'(v));
		send_word(1023);
		send_word(0);
		set_k(1);
		send_word(6);
		set_k(0);
		send_word(700);
		set_k(15);
		send_word(5);
		send_word(0);
		// Shrinking k leaves the slots above the spare slot untouched; growing it again shows them.
		set_k(3);
		send_word(11);
		set_k(8);
		send_word(11);
		send_word(0);

		for (int p = 0; p < 9; p++) begin
			set_k(TKF_KCFG_BITS'(k_plan[p]));
			for (int i = 0; i < POOL / 2; i++)
				pool[$urandom_range(0, POOL - 1)] = VB'($urandom_range(1, (1 << VB) - 1));
			calm = (p == 6);
			stall_en = (p != 6);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (p == 2 && i == 18)
					wait_idle();
				send_word(next_value());
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (pending != 0)
			$error("%0d expected result words never arrived", pending);
		$display("Run covered %0d input words and %0d checked result words", words_taken,
			results_checked);
		$display("across %0d rank-depth writes, out-of-range depths and back-to-back bursts",
			k_writes);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#30_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/tkf_pkg.sv
rtl/tkf_count_mem.sv
rtl/tkf_rank_list.sv
rtl/top_k_frequent_stream_top.sv
rtl/tkf_checker.sv
tb/tkf_ranking_checker.sv
tb/tb_top_k_frequent_stream_top.sv
